[src/osc_pkg.sv]
// shared types and constants for the ordered set ceiling query block
`timescale 1ns / 1ps
`default_nettype none

package osc_pkg;

  localparam int unsigned CapacityDefault = 1024;
  localparam int unsigned KeyWidth = 32;

  localparam logic ModeInsert = 1'b0;
  localparam logic ModeQuery  = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_QUERY     = 2'd3
  } status_e;

  typedef struct packed {
    logic                       mode;
    logic signed [KeyWidth-1:0] key;
  } in_req_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic                       found;
    logic signed [KeyWidth-1:0] ceiling_key;
  } out_rsp_t;

  typedef struct packed {
    logic    load;
    logic    rd_mid;
    logic    step;
    logic    shift_init;
    logic    shift_rd;
    logic    shift_wr;
    logic    place;
    logic    rsp_load;
    status_e rsp_status;
  } dp_cmd_t;

  typedef struct packed {
    logic mode;
    logic search_done;
    logic shift_done;
    logic dup;
    logic full;
  } dp_stat_t;

endpackage

`default_nettype wire

[src/osc_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module osc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[src/osc_datapath.sv]
// datapath: key store, binary search bounds, shift index, entry count, response register
`timescale 1ns / 1ps
`default_nettype none

module osc_datapath #(
  parameter int unsigned Capacity = osc_pkg::CapacityDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire osc_pkg::in_req_t   in_req_i,
  input  wire osc_pkg::dp_cmd_t   cmd_i,
  output osc_pkg::dp_stat_t       stat_o,
  output osc_pkg::out_rsp_t       out_rsp_o
);

  localparam int unsigned AddrW = $clog2(Capacity);
  localparam int unsigned CntW  = $clog2(Capacity + 1);
  localparam int unsigned KeyW  = osc_pkg::KeyWidth;

  logic                   mode_q;
  logic signed [KeyW-1:0] key_q;
  logic [CntW-1:0]        lo_q, lo_d;
  logic [CntW-1:0]        hi_q, hi_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [CntW-1:0]        count_q, count_d;
  logic signed [KeyW-1:0] cand_q, cand_d;
  osc_pkg::out_rsp_t      rsp_q;

  logic [CntW-1:0]        mid;
  logic [CntW-1:0]        idx_m1;
  logic                   ram_we;
  logic [AddrW-1:0]       ram_waddr;
  logic [KeyW-1:0]        ram_wdata;
  logic                   ram_re;
  logic [AddrW-1:0]       ram_raddr;
  logic [KeyW-1:0]        ram_rdata;
  logic                   pos_valid;

  assign mid       = lo_q + ((hi_q - lo_q) >> 1);
  assign idx_m1    = idx_q - CntW'(1);
  assign pos_valid = lo_q < count_q;

  osc_ram #(
    .Width (KeyW),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_re    = cmd_i.rd_mid | cmd_i.shift_rd;
    ram_raddr = cmd_i.shift_rd ? idx_m1[AddrW-1:0] : mid[AddrW-1:0];
    ram_we    = cmd_i.shift_wr | cmd_i.place;
    ram_waddr = cmd_i.place ? lo_q[AddrW-1:0] : idx_q[AddrW-1:0];
    ram_wdata = cmd_i.place ? key_q : ram_rdata;
  end

  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    idx_d   = idx_q;
    count_d = count_q;
    cand_d  = cand_q;
    if (cmd_i.load) begin
      lo_d = '0;
      hi_d = count_q;
    end
    if (cmd_i.step) begin
      if ($signed(ram_rdata) < key_q) begin
        lo_d = mid + CntW'(1);
      end else begin
        hi_d   = mid;
        cand_d = $signed(ram_rdata);
      end
    end
    if (cmd_i.shift_init) begin
      idx_d = count_q;
    end
    if (cmd_i.shift_wr) begin
      idx_d = idx_m1;
    end
    if (cmd_i.place) begin
      count_d = count_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    idx_q  <= idx_d;
    cand_q <= cand_d;
    if (cmd_i.load) begin
      mode_q <= in_req_i.mode;
      key_q  <= in_req_i.key;
    end
    if (cmd_i.rsp_load) begin
      rsp_q.status <= cmd_i.rsp_status;
      if (mode_q == osc_pkg::ModeQuery && pos_valid) begin
        rsp_q.found       <= 1'b1;
        rsp_q.ceiling_key <= cand_q;
      end else begin
        rsp_q.found       <= 1'b0;
        rsp_q.ceiling_key <= '0;
      end
    end
  end

  always_comb begin
    stat_o.mode        = mode_q;
    stat_o.search_done = !(lo_q < hi_q);
    stat_o.shift_done  = !(idx_q > lo_q);
    stat_o.dup         = pos_valid && (cand_q == key_q);
    stat_o.full        = count_q == CntW'(Capacity);
  end

  assign out_rsp_o = rsp_q;

endmodule

`default_nettype wire

[src/osc_ctrl.sv]
// controller: sequences search, shift and placement, owns the handshakes
`timescale 1ns / 1ps
`default_nettype none

module osc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire osc_pkg::dp_stat_t stat_i,
  output osc_pkg::dp_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESPOND
  } state_e;

  state_e           state_q;
  logic             out_valid_q;
  osc_pkg::status_e rsp_status_q;
  logic             out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.rsp_status = rsp_status_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.load = in_valid_i;
      end
      S_SEARCH_RD: begin
        if (!stat_i.search_done) begin
          cmd_o.rd_mid = 1'b1;
        end else if (stat_i.mode == osc_pkg::ModeInsert && !stat_i.dup && !stat_i.full) begin
          cmd_o.shift_init = 1'b1;
        end
      end
      S_SEARCH_CMP: begin
        cmd_o.step = 1'b1;
      end
      S_SHIFT_RD: begin
        if (stat_i.shift_done) begin
          cmd_o.place = 1'b1;
        end else begin
          cmd_o.shift_rd = 1'b1;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr = 1'b1;
      end
      S_RESPOND: begin
        cmd_o.rsp_load = out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      rsp_status_q <= osc_pkg::ST_INSERTED;
    end else begin
      if (state_q == S_RESPOND && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SEARCH_RD;
          end
        end
        S_SEARCH_RD: begin
          if (!stat_i.search_done) begin
            state_q <= S_SEARCH_CMP;
          end else if (stat_i.mode == osc_pkg::ModeQuery) begin
            rsp_status_q <= osc_pkg::ST_QUERY;
            state_q      <= S_RESPOND;
          end else if (stat_i.dup) begin
            rsp_status_q <= osc_pkg::ST_DUPLICATE;
            state_q      <= S_RESPOND;
          end else if (stat_i.full) begin
            rsp_status_q <= osc_pkg::ST_FULL;
            state_q      <= S_RESPOND;
          end else begin
            state_q <= S_SHIFT_RD;
          end
        end
        S_SEARCH_CMP: begin
          state_q <= S_SEARCH_RD;
        end
        S_SHIFT_RD: begin
          if (stat_i.shift_done) begin
            rsp_status_q <= osc_pkg::ST_INSERTED;
            state_q      <= S_RESPOND;
          end else begin
            state_q <= S_SHIFT_WR;
          end
        end
        S_SHIFT_WR: begin
          state_q <= S_SHIFT_RD;
        end
        S_RESPOND: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[src/ordered_set_ceiling_query.sv]
// top level of the ordered set with insert and ceiling query
`timescale 1ns / 1ps
`default_nettype none

// Keeps up to Capacity distinct signed keys in ascending order in one RAM
// and answers each request with one response. A request first runs a
// binary search over the n stored keys in at most ceil(log2(n+1)) steps,
// each a read state and a compare state, as the RAM read data is
// registered. A query or a rejected insert then responds; a new key
// shifts the n-pos larger keys up one slot, each read and written back
// over the single read and write ports, and is then placed. One request
// is in work at a time; the response register lets the next request
// enter while a response waits. The RAM needs no clearing after reset,
// only slots below the entry count are read.
module ordered_set_ceiling_query #(
  parameter int unsigned Capacity = osc_pkg::CapacityDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire osc_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output osc_pkg::out_rsp_t      out_rsp_o
);

  osc_pkg::dp_cmd_t  cmd;
  osc_pkg::dp_stat_t stat;

  osc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  osc_datapath #(
    .Capacity (Capacity)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_rsp_o (out_rsp_o)
  );

endmodule

`default_nettype wire

[dv/tb_ordered_set_ceiling_query.sv]
// testbench for the ordered set with insert and ceiling query
`timescale 1ns / 1ps

module tb_ordered_set_ceiling_query;

  localparam int unsigned Capacity = osc_pkg::CapacityDefault;
  localparam int unsigned WatchdogLimit = 10000;
  localparam int unsigned DrainCycles = 64;
  localparam logic signed [osc_pkg::KeyWidth-1:0] KeyMin = 32'sh8000_0000;
  localparam logic signed [osc_pkg::KeyWidth-1:0] KeyMax = 32'sh7fff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  osc_pkg::in_req_t in_req = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  osc_pkg::out_rsp_t out_rsp_o;

  logic tx_quiet = 1'b0;
  logic rx_quiet = 1'b0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  logic signed [osc_pkg::KeyWidth-1:0] held_keys [Capacity];
  int held_count = 0;
  osc_pkg::out_rsp_t owed_rsps [$];

  ordered_set_ceiling_query #(
    .Capacity(Capacity)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_rsp_o  (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  // first slot holding a key not less than the given one
  function automatic int ceiling_pos(input logic signed [osc_pkg::KeyWidth-1:0] key);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = held_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (held_keys[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return lo;
  endfunction

  function automatic osc_pkg::out_rsp_t run_set_op(
      input logic mode,
      input logic signed [osc_pkg::KeyWidth-1:0] key);
    osc_pkg::out_rsp_t rsp;
    int pos;
    rsp = '0;
    pos = ceiling_pos(key);
    if (mode == osc_pkg::ModeQuery) begin
      rsp.status = osc_pkg::ST_QUERY;
      if (pos < held_count) begin
        rsp.found = 1'b1;
        rsp.ceiling_key = held_keys[pos];
      end
    end else if (pos < held_count && held_keys[pos] == key) begin
      rsp.status = osc_pkg::ST_DUPLICATE;
    end else if (held_count >= Capacity) begin
      rsp.status = osc_pkg::ST_FULL;
    end else begin
      for (int i = held_count; i > pos; i--) begin
        held_keys[i] = held_keys[i-1];
      end
      held_keys[pos] = key;
      held_count++;
      rsp.status = osc_pkg::ST_INSERTED;
    end
    return rsp;
  endfunction

  function automatic int pick_gap(input logic quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) begin
      return 0;
    end
    if (r < 96) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [osc_pkg::KeyWidth-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return int'($urandom_range(0, 511)) - 256;
    end
    if (r < 65 && held_count > 0) begin
      return held_keys[$urandom_range(0, held_count - 1)] + int'($urandom_range(0, 2)) - 1;
    end
    if (r < 75) begin
      case ($urandom_range(0, 3))
        0: return KeyMin;
        1: return KeyMax;
        2: return 0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic pick_mode();
    return $urandom_range(0, 1) ? osc_pkg::ModeQuery : osc_pkg::ModeInsert;
  endfunction

  task automatic issue_request(input logic mode,
                               input logic signed [osc_pkg::KeyWidth-1:0] key);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req <= '{mode: mode, key: key};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    owed_rsps.push_back(run_set_op(mode, key));
  endtask

  task automatic wait_all_answered();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (owed_rsps.size() != 0);
  endtask

  task automatic test_directed();
    issue_request(osc_pkg::ModeQuery, KeyMin);
    issue_request(osc_pkg::ModeQuery, 0);
    issue_request(osc_pkg::ModeQuery, KeyMax);
    issue_request(osc_pkg::ModeInsert, 0);
    issue_request(osc_pkg::ModeInsert, 0);
    issue_request(osc_pkg::ModeInsert, -1);
    issue_request(osc_pkg::ModeInsert, 1);
    issue_request(osc_pkg::ModeInsert, KeyMin);
    issue_request(osc_pkg::ModeInsert, KeyMin);
    issue_request(osc_pkg::ModeQuery, KeyMin);
    issue_request(osc_pkg::ModeQuery, -5);
    issue_request(osc_pkg::ModeQuery, 0);
    issue_request(osc_pkg::ModeQuery, 1);
    issue_request(osc_pkg::ModeQuery, 2);
    issue_request(osc_pkg::ModeQuery, KeyMax);
    issue_request(osc_pkg::ModeInsert, KeyMax);
    issue_request(osc_pkg::ModeQuery, KeyMax);
    issue_request(osc_pkg::ModeQuery, 2);
    issue_request(osc_pkg::ModeQuery, KeyMax - 1);
    issue_request(osc_pkg::ModeInsert, KeyMax - 1);
    issue_request(osc_pkg::ModeQuery, KeyMin + 1);
  endtask

  task automatic test_random_mix();
    repeat (400) issue_request(pick_mode(), pick_key());
  endtask

  // ascending keys above most of the set keep the shifts short
  task automatic test_fill_to_capacity();
    logic signed [osc_pkg::KeyWidth-1:0] fill_key;
    fill_key = 32'sh4000_0000;
    wait_all_answered();
    while (held_count < Capacity) begin
      if ($urandom_range(0, 3) == 0) begin
        issue_request(osc_pkg::ModeQuery, pick_key());
      end else begin
        issue_request(osc_pkg::ModeInsert, fill_key);
        fill_key += 7;
      end
    end
  endtask

  task automatic test_full_store();
    repeat (200) begin
      if ($urandom_range(0, 1)) begin
        issue_request(osc_pkg::ModeInsert, ($urandom_range(0, 1)) ? $urandom : pick_key());
      end else begin
        issue_request(osc_pkg::ModeQuery, pick_key());
      end
    end
  endtask

  always @(posedge clk_i) begin
    if ($urandom_range(0, 499) == 0) tx_quiet <= ~tx_quiet;
    if ($urandom_range(0, 499) == 0) rx_quiet <= ~rx_quiet;
  end

  initial begin
    int stall;
    osc_pkg::out_rsp_t exp_rsp;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready) begin
        if (owed_rsps.size() == 0) begin
          $error("response with none pending: status %0d key %0d",
                 out_rsp_o.status, out_rsp_o.ceiling_key);
          errors++;
        end else begin
          exp_rsp = owed_rsps.pop_front();
          if (out_rsp_o.status !== exp_rsp.status) begin
            $error("status: expected %0d, got %0d", exp_rsp.status, out_rsp_o.status);
            errors++;
          end
          if (out_rsp_o.found !== exp_rsp.found) begin
            $error("found: expected %0d, got %0d", exp_rsp.found, out_rsp_o.found);
            errors++;
          end
          if (out_rsp_o.ceiling_key !== exp_rsp.ceiling_key) begin
            $error("ceiling_key: expected %0d, got %0d",
                   exp_rsp.ceiling_key, out_rsp_o.ceiling_key);
            errors++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        stall = pick_gap(rx_quiet);
        out_ready <= (stall == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb_ordered_set_ceiling_query: errors");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix();
    test_fill_to_capacity();
    test_full_store();
    wait_all_answered();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_ordered_set_ceiling_query: clean");
    end else begin
      $display("tb_ordered_set_ceiling_query: errors");
    end
    $finish;
  end

endmodule
